>>> hdl/tcpu_pkg.sv
// tcpu_pkg: shared types and constants of the tiny cpu execute step
// no dependencies; compiled first

package tcpu_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

   localparam int DATA_W      = 8;
   localparam int ADDR_W      = 12;
   localparam int INST_W      = 16;
   localparam int NUM_REGS    = 16;
   localparam int REG_IDX_W   = 4;

   localparam logic [ADDR_W-1:0] START_ADDRESS_RESET = 12'd512;

   typedef enum logic [3:0] {
      OP_LD   = 4'h0,
      OP_MV   = 4'h1,
      OP_ADD  = 4'h2,
      OP_SUB  = 4'h3,
      OP_MULT = 4'h4,
      OP_DIV  = 4'h5,
      OP_MOD  = 4'h6,
      OP_SKP  = 4'h7,
      OP_SNE  = 4'h8,
      OP_J    = 4'h9,
      OP_CALL = 4'hA,
      OP_RET  = 4'hB,
      OP_LA   = 4'hC,
      OP_SRA  = 4'hD,
      OP_SLA  = 4'hE,
      OP_WA   = 4'hF
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_DIV_ZERO  = 2'd1,
      FAULT_OVERFLOW  = 2'd2,
      FAULT_UNDERFLOW = 2'd3
   } fault_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_DIV  = 4'b0100,
      S_WAIT = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_div;
      logic div_last;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] next_pc;
      logic              mem_write;
      logic [7:0]        mem_write_addr;
      logic [DATA_W-1:0] mem_write_data;
      logic [DATA_W-1:0] dest_value;
      logic [DATA_W-1:0] flag_value;
      logic [ADDR_W-1:0] address_value;
      fault_type         fault;
   } rsp_payload_type;

endpackage

>>> hdl/tcpu_channels.sv
// tcpu_channels: valid/ready channel interfaces of the tiny cpu execute step
// depends on tcpu_pkg

interface tcpu_req_if import tcpu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [INST_W-1:0] instruction_word;

   modport source (output valid, output instruction_word, input ready);
   modport sink   (input valid, input instruction_word, output ready);
endinterface

interface tcpu_rsp_if import tcpu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] next_pc;
   logic              mem_write;
   logic [7:0]        mem_write_addr;
   logic [DATA_W-1:0] mem_write_data;
   logic [DATA_W-1:0] dest_value;
   logic [DATA_W-1:0] flag_value;
   logic [ADDR_W-1:0] address_value;
   logic [1:0]        fault;

   modport source (output valid, output next_pc, output mem_write, output mem_write_addr,
                   output mem_write_data, output dest_value, output flag_value,
                   output address_value, output fault, input ready);
   modport sink   (input valid, input next_pc, input mem_write, input mem_write_addr,
                   input mem_write_data, input dest_value, input flag_value,
                   input address_value, input fault, output ready);
endinterface

interface tcpu_csr_if import tcpu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] start_address;

   modport source (output valid, output start_address, input ready);
   modport sink   (input valid, input start_address, output ready);
endinterface

>>> hdl/tcpu_ram.sv
// tcpu_ram: generic single-write, single-read ram with registered read data
// no dependencies

module tcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/tcpu_divider.sv
// tcpu_divider: restoring divider, one quotient bit per cycle
// depends on tcpu_pkg

module tcpu_divider import tcpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              last,
   output logic [DATA_W-1:0] quotient,
   output logic [DATA_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff, quo_ff[DATA_W-1]};
      diff     = trial - {1'b0, divisor};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         count_in = count_ff + CNT_W'(1);
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         if (count_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign last      = busy_ff && (count_ff == CNT_W'(DATA_W - 1));
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/tcpu_datapath.sv
// tcpu_datapath: register file, stack, architectural registers, alu and result register
// depends on tcpu_pkg, tcpu_channels, tcpu_ram, tcpu_divider

module tcpu_datapath import tcpu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic [INST_W-1:0] instruction_word,
   tcpu_rsp_if.source        rsp_ch,
   tcpu_csr_if.sink          csr_ch
);

   logic [INST_W-1:0]      inst_ff;
   logic [ADDR_W-1:0]      pc_ff, pc_in;
   logic [DATA_W-1:0]      flag_ff, flag_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [NUM_REGS-1:0]    reg_valid_ff;
   logic [ADDR_W-1:0]      start_address_ff;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_ff;

   op_type                 op;
   logic [REG_IDX_W-1:0]   x_idx, y_idx;
   logic [7:0]             imm;
   logic [ADDR_W-1:0]      target;
   logic [DATA_W-1:0]      ram_x_rdata, ram_y_rdata, vx, vy;
   logic [ADDR_W-1:0]      stack_rdata;
   logic [LEVEL_W-1:0]     level_dec;
   logic [2*DATA_W-1:0]    product;
   logic [DATA_W-1:0]      shr, shl;
   logic [DATA_W-1:0]      quotient, remainder;
   logic                   div_last;
   logic [ADDR_W-1:0]      pc_plus1, pc_plus2;

   logic                   dest_we;
   logic [DATA_W-1:0]      dest_new;
   logic                   push, pop;
   rsp_payload_type        result;

   assign op     = op_type'(inst_ff[15:12]);
   assign x_idx  = inst_ff[11:8];
   assign y_idx  = inst_ff[7:4];
   assign imm    = inst_ff[7:0];
   assign target = inst_ff[ADDR_W-1:0];

   // two copies of the register file give the two read ports
   tcpu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_regs_x (
      .clock (clock),
      .we    (cmd.commit && dest_we),
      .waddr (x_idx),
      .wdata (dest_new),
      .re    (cmd.capture),
      .raddr (instruction_word[11:8]),
      .rdata (ram_x_rdata)
   );

   tcpu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_regs_y (
      .clock (clock),
      .we    (cmd.commit && dest_we),
      .waddr (x_idx),
      .wdata (dest_new),
      .re    (cmd.capture),
      .raddr (instruction_word[7:4]),
      .rdata (ram_y_rdata)
   );

   assign level_dec = level_ff - LEVEL_W'(1);

   tcpu_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (cmd.commit && push),
      .waddr (level_ff[STACK_IDX_W-1:0]),
      .wdata (pc_plus1),
      .re    (cmd.capture),
      .raddr (level_dec[STACK_IDX_W-1:0]),
      .rdata (stack_rdata)
   );

   // never-written registers read as zero
   assign vx = reg_valid_ff[x_idx] ? ram_x_rdata : '0;
   assign vy = reg_valid_ff[y_idx] ? ram_y_rdata : '0;

   tcpu_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (vx),
      .divisor   (vy),
      .last      (div_last),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign product  = vx * vy;
   assign shr      = (vy >= DATA_W'(8)) ? '0 : (vx >> vy[2:0]);
   assign shl      = (vy >= DATA_W'(8)) ? '0 : (vx << vy[2:0]);
   assign pc_plus1 = pc_ff + ADDR_W'(1);
   assign pc_plus2 = pc_ff + ADDR_W'(2);

   always_comb begin
      dest_we  = 1'b0;
      dest_new = vx;
      flag_in  = flag_ff;
      addr_in  = addr_ff;
      pc_in    = pc_plus1;
      level_in = level_ff;
      push     = 1'b0;
      pop      = 1'b0;
      result   = '0;
      result.fault = FAULT_NONE;
      case (op)
         OP_LD: begin
            dest_we  = 1'b1;
            dest_new = imm;
         end
         OP_MV: begin
            dest_we  = 1'b1;
            dest_new = vy;
         end
         OP_ADD: begin
            dest_we  = 1'b1;
            dest_new = vx + vy;
         end
         OP_SUB: begin
            dest_we  = 1'b1;
            dest_new = vx - vy;
         end
         OP_MULT: begin
            dest_we  = 1'b1;
            dest_new = product[DATA_W-1:0];
         end
         OP_DIV: begin
            if (vy == '0) begin
               result.fault = FAULT_DIV_ZERO;
            end else begin
               dest_we  = 1'b1;
               dest_new = quotient;
            end
         end
         OP_MOD: begin
            if (vy == '0) begin
               result.fault = FAULT_DIV_ZERO;
            end else begin
               flag_in = remainder;
            end
         end
         OP_SKP: begin
            if (vx == vy) begin
               pc_in = pc_plus2;
            end
         end
         OP_SNE: begin
            if (vx != vy) begin
               pc_in = pc_plus2;
            end
         end
         OP_J: begin
            pc_in = target;
         end
         OP_CALL: begin
            if (level_ff >= LEVEL_W'(STACK_DEPTH)) begin
               result.fault = FAULT_OVERFLOW;
            end else begin
               push     = 1'b1;
               level_in = level_ff + LEVEL_W'(1);
               pc_in    = target;
            end
         end
         OP_RET: begin
            if (level_ff == '0) begin
               result.fault = FAULT_UNDERFLOW;
            end else begin
               pop      = 1'b1;
               level_in = level_dec;
               pc_in    = stack_rdata;
            end
         end
         OP_LA: begin
            addr_in = target;
         end
         OP_SRA: begin
            dest_we  = 1'b1;
            dest_new = shr;
            flag_in  = {7'd0, shr[DATA_W-1]};
         end
         OP_SLA: begin
            dest_we  = 1'b1;
            dest_new = shl;
            flag_in  = {7'd0, shl[DATA_W-1]};
         end
         OP_WA: begin
            result.mem_write      = 1'b1;
            result.mem_write_addr = imm;
            result.mem_write_data = vx;
         end
         default: begin
            dest_we = 1'b0;
         end
      endcase
      result.next_pc       = pc_in;
      result.dest_value    = dest_new;
      result.flag_value    = flag_in;
      result.address_value = addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff            <= START_ADDRESS_RESET;
         flag_ff          <= '0;
         addr_ff          <= '0;
         level_ff         <= '0;
         reg_valid_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         start_address_ff <= START_ADDRESS_RESET;
      end else begin
         if (cmd.commit) begin
            pc_ff    <= pc_in;
            flag_ff  <= flag_in;
            addr_ff  <= addr_in;
            level_ff <= level_in;
            if (dest_we) begin
               reg_valid_ff[x_idx] <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // boot vector register; the core starts from its reset value
         if (csr_ch.valid) begin
            start_address_ff <= csr_ch.start_address;
         end
      end
      if (cmd.capture) begin
         inst_ff <= instruction_word;
      end
      if (cmd.commit) begin
         rsp_ff <= result;
      end
   end

   assign csr_ch.ready = 1'b1;

   assign status.needs_div = ((op == OP_DIV) || (op == OP_MOD)) && (vy != '0);
   assign status.div_last  = div_last;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.next_pc        = rsp_ff.next_pc;
   assign rsp_ch.mem_write      = rsp_ff.mem_write;
   assign rsp_ch.mem_write_addr = rsp_ff.mem_write_addr;
   assign rsp_ch.mem_write_data = rsp_ff.mem_write_data;
   assign rsp_ch.dest_value     = rsp_ff.dest_value;
   assign rsp_ch.flag_value     = rsp_ff.flag_value;
   assign rsp_ch.address_value  = rsp_ff.address_value;
   assign rsp_ch.fault          = rsp_ff.fault;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_fault_keeps_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (result.fault != FAULT_NONE) |=>
         (flag_ff == $past(flag_ff)) && (level_ff == $past(level_ff)))
      else $error("faulting instruction changed flag or stack");

   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (rsp_ff.next_pc == pc_ff))
      else $error("result beat does not match program counter");

   a_csr_capture: assert property (@(posedge clock) disable iff (reset)
      csr_ch.valid |=> start_address_ff == $past(csr_ch.start_address))
      else $error("boot vector write lost");

endmodule

>>> hdl/tcpu_controller.sv
// tcpu_controller: sequencing state machine of the execute step
// depends on tcpu_pkg

module tcpu_controller import tcpu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_DIV: begin
            if (status.div_last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit && (state_ff == S_IDLE))
      else $error("double commit");

   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EXEC)
      else $error("capture not followed by execute");

   a_no_commit_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !cmd.commit && !cmd.capture)
      else $error("commit or capture while dividing");

endmodule

>>> hdl/tiny_cpu_execute_step.sv
// tiny_cpu_execute_step: top level, one 16-bit instruction executed per request beat
// depends on tcpu_pkg, tcpu_channels, tcpu_controller, tcpu_datapath
//
//   channel  | direction | payload                                   | beat
//   req_ch   | in        | instruction_word[15:0]                    | valid & ready
//   rsp_ch   | out       | next_pc, mem_write*, dest/flag/address,   | valid & ready
//            |           | fault                                     |
//   csr_ch   | in        | start_address[11:0]                       | valid & ready
//
// most instructions: accept plus register file read, then execute and commit once the result slot is free
// div and mod with a nonzero divisor also run the 8-step restoring divider before commit
// one instruction in flight; the next request beat is taken while a result beat waits
// a stalled result beat holds execution of the next instruction in its commit cycle
// synchronous reset: pc to 512, registers, flag, address and stack level to zero
// csr writes are always taken; reset, not the csr value, sets the boot pc

module tiny_cpu_execute_step import tcpu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tcpu_req_if.sink  req_ch,
   tcpu_rsp_if.source rsp_ch,
   tcpu_csr_if.sink  csr_ch
);

   // command and status between sequencer and datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: idle, execute, divide, wait-for-result-slot
   tcpu_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: register file, return stack, alu, divider, result register
   tcpu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .instruction_word (req_ch.instruction_word),
      .rsp_ch           (rsp_ch),
      .csr_ch           (csr_ch)
   );

endmodule

>>> tb/tiny_cpu_execute_step_tb.sv
`timescale 1ns / 1ps
// tiny_cpu_execute_step_tb: self-checking bench for the tiny cpu execute step, directed
// edge cases then random programs; depends on tcpu_pkg, tcpu_channels and the block's rtl

module tiny_cpu_execute_step_tb;
   import tcpu_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 20;    // well past the end of a divide
   localparam int HOLD_OFF_CYCLES = 300;   // long result stall used to back up the block
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any beat before giving up

   logic clock;
   logic reset;

   tcpu_req_if req_ch ();
   tcpu_rsp_if rsp_ch ();
   tcpu_csr_if csr_ch ();

   tiny_cpu_execute_step u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow machine state, advanced once per accepted instruction beat
   // the boot pc is only loaded by reset, and reset is applied once
   logic [DATA_W-1:0] cpu_regs [NUM_REGS] = '{default: '0};
   logic [ADDR_W-1:0] cpu_pc      = START_ADDRESS_RESET;
   logic [DATA_W-1:0] cpu_flag    = '0;
   logic [ADDR_W-1:0] cpu_addr    = '0;
   logic [ADDR_W-1:0] call_stack [STACK_DEPTH];
   logic [LEVEL_W-1:0] call_depth = '0;

   rsp_payload_type pending_results [$];

   // stimulus knobs for the request side and the ready driver
   bit source_gaps;
   bit sink_stalls;
   bit hold_off_request;

   // bookkeeping for the run summary
   int instructions_sent;
   int results_checked;
   int error_count;
   int csr_writes;
   int hold_offs;
   int skips_taken;
   int mem_writes;
   int fault_tally [4];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor: executes one instruction on the shadow state
   // ------------------------------------------------------------------------
   function automatic rsp_payload_type execute_instruction(input logic [INST_W-1:0] word);
      rsp_payload_type   res;
      op_type            op;
      logic [3:0]        x, y;
      logic [DATA_W-1:0] vx, vy, shifted;
      logic [ADDR_W-1:0] target, npc;
      op     = op_type'(word[15:12]);
      x      = word[11:8];
      y      = word[7:4];
      vx     = cpu_regs[x];
      vy     = cpu_regs[y];
      target = word[11:0];
      npc    = cpu_pc + 12'd1;
      res    = '0;
      case (op)
         OP_LD:   cpu_regs[x] = word[7:0];
         OP_MV:   cpu_regs[x] = vy;
         OP_ADD:  cpu_regs[x] = vx + vy;
         OP_SUB:  cpu_regs[x] = vx - vy;
         OP_MULT: cpu_regs[x] = vx * vy;
         OP_DIV: begin
            // zero divisor leaves x alone
            if (vy == 0) res.fault = FAULT_DIV_ZERO;
            else cpu_regs[x] = vx / vy;
         end
         OP_MOD: begin
            if (vy == 0) res.fault = FAULT_DIV_ZERO;
            else cpu_flag = vx % vy;
         end
         OP_SKP: begin
            if (vx == vy) npc = cpu_pc + 12'd2;
         end
         OP_SNE: begin
            if (vx != vy) npc = cpu_pc + 12'd2;
         end
         OP_J: npc = target;
         OP_CALL: begin
            if (call_depth >= STACK_DEPTH) begin
               res.fault = FAULT_OVERFLOW;
            end else begin
               call_stack[call_depth] = cpu_pc + 12'd1;
               call_depth = call_depth + 1'b1;
               npc = target;
            end
         end
         OP_RET: begin
            if (call_depth == 0) begin
               res.fault = FAULT_UNDERFLOW;
            end else begin
               call_depth = call_depth - 1'b1;
               npc = call_stack[call_depth];
            end
         end
         OP_LA: cpu_addr = target;
         OP_SRA, OP_SLA: begin
            // counts of 8 and up clear the register in both directions
            if (vy >= 8) shifted = '0;
            else if (op == OP_SRA) shifted = vx >> vy[2:0];
            else shifted = vx << vy[2:0];
            cpu_regs[x] = shifted;
            cpu_flag = {7'd0, shifted[7]};
         end
         default: begin
            res.mem_write      = 1'b1;
            res.mem_write_addr = word[7:0];
            res.mem_write_data = vx;
         end
      endcase
      if (npc == cpu_pc + 12'd2) skips_taken++;
      cpu_pc = npc;
      res.next_pc       = npc;
      res.dest_value    = cpu_regs[x];
      res.flag_value    = cpu_flag;
      res.address_value = cpu_addr;
      if (res.mem_write) mem_writes++;
      fault_tally[res.fault]++;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // op, x, low byte; low byte carries y in its upper nibble or an immediate,
   // and x with the low byte together form a 12-bit target
   function automatic logic [INST_W-1:0] encode(input op_type op, input logic [3:0] x,
                                                input logic [7:0] low);
      return {op, x, low};
   endfunction

   // mostly no gap, some short, a few long
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [INST_W-1:0] random_instruction();
      logic [3:0] op;
      logic [7:0] low;
      op = 4'($urandom_range(0, 15));
      // reseed registers often so divides, skips and shifts see useful values
      if ($urandom_range(0, 3) == 0) op = OP_LD;
      low = 8'($urandom_range(0, 255));
      if (op == OP_LD) begin
         case ($urandom_range(0, 7))
            0, 1, 2: low = 8'($urandom_range(0, 9));
            3: begin
               case ($urandom_range(0, 3))
                  0: low = 8'h00;
                  1: low = 8'h7F;
                  2: low = 8'h80;
                  default: low = 8'hFF;
               endcase
            end
            default: ;
         endcase
      end
      return {op, 4'($urandom_range(0, 15)), low};
   endfunction

   // one instruction beat; the shadow machine steps at the accepting edge
   task automatic send_instruction(input logic [INST_W-1:0] word);
      int unsigned gap;
      gap = source_gaps ? idle_length() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.instruction_word <= word;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(execute_instruction(word));
      instructions_sent++;
   endtask

   // drop valid and wait until every result beat is back and the block is quiet
   task automatic settle_block();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_address(input logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_ch.valid         <= 1'b1;
      csr_ch.start_address <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_writes++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // nested calls followed by returns, with enough of each to hit the stack limits
   task automatic call_return_burst(input int unsigned depth);
      int unsigned returns;
      returns = depth + $urandom_range(0, 2);
      repeat (depth) send_instruction(encode(OP_CALL, 4'($urandom_range(0, 15)),
                                             8'($urandom_range(0, 255))));
      repeat (returns) send_instruction(encode(OP_RET, 4'($urandom_range(0, 15)),
                                               8'($urandom_range(0, 255))));
   endtask

   // ------------------------------------------------------------------------
   // test tasks
   // ------------------------------------------------------------------------

   // wrapping arithmetic, zero divisor on both div and mod, a clean divide
   task automatic test_arith_edges();
      send_instruction(encode(OP_LD,   4'h1, 8'hFF));
      send_instruction(encode(OP_LD,   4'h2, 8'h01));
      send_instruction(encode(OP_ADD,  4'h1, 8'h20));   // ff + 1 wraps to 0
      send_instruction(encode(OP_SUB,  4'h3, 8'h20));   // 0 - 1 wraps to ff
      send_instruction(encode(OP_MULT, 4'h3, 8'h30));   // ff * ff keeps low byte
      send_instruction(encode(OP_DIV,  4'h1, 8'h40));   // r4 is still zero
      send_instruction(encode(OP_MOD,  4'h3, 8'h00));
      send_instruction(encode(OP_LD,   4'h5, 8'hF7));
      send_instruction(encode(OP_LD,   4'h6, 8'h0A));
      send_instruction(encode(OP_DIV,  4'h5, 8'h60));
      send_instruction(encode(OP_MOD,  4'h5, 8'h60));
      send_instruction(encode(OP_MV,   4'hF, 8'h50));
   endtask

   // skips taken and not taken, shift counts 0, 7 and 8
   task automatic test_skips_and_shifts();
      send_instruction(encode(OP_SKP, 4'h0, 8'h10));
      send_instruction(encode(OP_SKP, 4'h5, 8'h60));
      send_instruction(encode(OP_SNE, 4'h5, 8'h60));
      send_instruction(encode(OP_SNE, 4'h0, 8'h00));
      send_instruction(encode(OP_LD,  4'h8, 8'h08));
      send_instruction(encode(OP_LD,  4'h9, 8'h07));
      send_instruction(encode(OP_SLA, 4'h3, 8'h90));    // 1 << 7 sets the flag
      send_instruction(encode(OP_SRA, 4'h3, 8'h90));
      send_instruction(encode(OP_SLA, 4'h3, 8'h80));    // count of 8 clears
      send_instruction(encode(OP_LD,  4'hA, 8'hFF));
      send_instruction(encode(OP_SRA, 4'hA, 8'h00));    // count 0 keeps ff
   endtask

   // empty stack return, call and return across the top of the address space,
   // pc wrap on plain advance and on a skip, memory write requests
   task automatic test_control_flow();
      send_instruction(encode(OP_RET,  4'h0, 8'h00));
      send_instruction(encode(OP_LA,   4'hF, 8'hFF));
      send_instruction(encode(OP_CALL, 4'hF, 8'hFF));
      send_instruction(encode(OP_SKP,  4'h0, 8'h00));   // fff + 2 wraps to 001
      send_instruction(encode(OP_RET,  4'h0, 8'h00));
      send_instruction(encode(OP_J,    4'hF, 8'hFF));
      send_instruction(encode(OP_WA,   4'hA, 8'hFF));   // fff + 1 wraps to 000
      send_instruction(encode(OP_WA,   4'h0, 8'h00));
   endtask

   // random program; pressure asks for two long result stalls, at the start and mid phase
   task automatic test_random_program(input int count, input bit gaps, input bit stalls,
                                      input bit pressure);
      int goal;
      int mid;
      bit second_hold;
      goal        = instructions_sent + count;
      mid         = instructions_sent + count / 2;
      second_hold = 1'b0;
      source_gaps = gaps;
      sink_stalls = stalls;
      if (pressure) hold_off_request = 1'b1;
      while (instructions_sent < goal) begin
         if ($urandom_range(0, 19) == 0)
            call_return_burst($urandom_range(1, STACK_DEPTH + 3));
         else
            send_instruction(random_instruction());
         if (pressure && !second_hold && instructions_sent >= mid) begin
            hold_off_request = 1'b1;
            second_hold      = 1'b1;
         end
      end
      settle_block();
   endtask

   // ------------------------------------------------------------------------
   // result side: ready driver and checker
   // ------------------------------------------------------------------------

   // a hold-off request turns into one long stall counted here
   initial begin : rsp_ready_drive
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         stall = sink_stalls ? idle_length() : 0;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall            = HOLD_OFF_CYCLES;
            hold_offs++;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // every result beat is matched against the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no instruction outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("next_pc",        16'(want.next_pc),        16'(rsp_ch.next_pc));
            check_field("mem_write",      16'(want.mem_write),      16'(rsp_ch.mem_write));
            check_field("mem_write_addr", 16'(want.mem_write_addr),
                        16'(rsp_ch.mem_write_addr));
            check_field("mem_write_data", 16'(want.mem_write_data),
                        16'(rsp_ch.mem_write_data));
            check_field("dest_value",     16'(want.dest_value),     16'(rsp_ch.dest_value));
            check_field("flag_value",     16'(want.flag_value),     16'(rsp_ch.flag_value));
            check_field("address_value",  16'(want.address_value),
                        16'(rsp_ch.address_value));
            check_field("fault",          16'(want.fault),          16'(rsp_ch.fault));
            results_checked++;
         end
      end
   end

   // no beat on any channel for too long means the block is stuck
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("timeout: no beat for %0d cycles, %0d results outstanding",
                quiet_cycles, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.instruction_word <= '0;
      csr_ch.valid            <= 1'b0;
      csr_ch.start_address    <= '0;
      source_gaps              = 1'b0;
      sink_stalls              = 1'b0;
      hold_off_request         = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // boot pc was latched by reset, so this write must not move the pc
      write_start_address(12'hFFF);
      test_arith_edges();
      test_skips_and_shifts();
      test_control_flow();
      settle_block();

      // back to back beats, one stack burst deep enough to overflow
      write_start_address(12'h000);
      call_return_burst(STACK_DEPTH + 2);
      test_random_program(250, 1'b0, 1'b0, 1'b0);

      // idling on both sides
      write_start_address(12'($urandom_range(0, 4095)));
      test_random_program(300, 1'b1, 1'b1, 1'b0);

      // sender keeps offering while results are held off
      write_start_address(START_ADDRESS_RESET);
      test_random_program(250, 1'b0, 1'b0, 1'b1);

      write_start_address(12'hFFF);
      test_random_program(300, 1'b1, 1'b1, 1'b0);

      settle_block();
      $display("run: %0d instructions, %0d results checked, %0d boot pc writes, %0d hold-offs",
               instructions_sent, results_checked, csr_writes, hold_offs);
      $display("seen: %0d div by zero, %0d overflow, %0d underflow, %0d skips, %0d mem writes",
               fault_tally[FAULT_DIV_ZERO], fault_tally[FAULT_OVERFLOW],
               fault_tally[FAULT_UNDERFLOW], skips_taken, mem_writes);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
